>>> design/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> design/knnsrc_pkg.sv
package knnsrc_pkg;

    localparam int IDX_W     = 16;
    localparam int OUT_CNT_W = 16;
    localparam int MODE_W    = 2;

    localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EDGE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  pixel_index;
        logic [IDX_W-1:0]  neighbor_index;
        logic              region_bit;
    } t_in_beat;

    typedef struct packed {
        logic [IDX_W-1:0]     pixel_index_out;
        logic [OUT_CNT_W-1:0] region_count;
    } t_out_beat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD_P,
        S_UPD_Q,
        S_LOAD,
        S_READ
    } t_state;

    typedef struct packed {
        logic accept;
        logic upd_p;
        logic upd_q;
        logic clr;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

>>> design/knnsrc_ctrl.sv
module knnsrc_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [knnsrc_pkg::MODE_W-1:0] i_mode,
    input  knnsrc_pkg::t_dp_sts           i_sts,
    output logic                          o_in_ready,
    output knnsrc_pkg::t_dp_cmd           o_cmd
);
    import knnsrc_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   in_ready;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // states where the count write port is free for the next beat
    assign in_ready = (r_state == S_IDLE) || (r_state == S_UPD_Q) || (r_state == S_LOAD);
    assign accept   = i_in_valid && in_ready;

    always_comb begin
        n_state = r_state;
        if (accept) begin
            case (i_mode)
                MODE_LOAD: n_state = S_LOAD;
                MODE_EDGE: n_state = S_UPD_P;
                MODE_READ: n_state = S_READ;
                default:   n_state = S_IDLE;
            endcase
        end else begin
            case (r_state)
                S_IDLE:  n_state = S_IDLE;
                S_UPD_P: n_state = S_UPD_Q;
                S_UPD_Q: n_state = S_IDLE;
                S_LOAD:  n_state = S_IDLE;
                S_READ:  n_state = i_sts.out_free ? S_IDLE : S_READ;
                default: n_state = S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_in_ready   = in_ready;
        o_cmd.accept = accept;
        o_cmd.upd_p  = 1'b0;
        o_cmd.upd_q  = 1'b0;
        o_cmd.clr    = 1'b0;
        o_cmd.emit   = 1'b0;
        case (r_state)
            S_UPD_P: o_cmd.upd_p = 1'b1;
            S_UPD_Q: o_cmd.upd_q = 1'b1;
            S_LOAD:  o_cmd.clr   = 1'b1;
            S_READ:  o_cmd.emit  = i_sts.out_free;
            default: o_cmd.upd_p = 1'b0;
        endcase
    end

endmodule

>>> design/knnsrc_datapath.sv
module knnsrc_datapath #(
    parameter int PIXELS     = 65536,
    parameter int COUNT_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  knnsrc_pkg::t_dp_cmd  i_cmd,
    output knnsrc_pkg::t_dp_sts  o_sts,
    input  knnsrc_pkg::t_in_beat i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output knnsrc_pkg::t_out_beat o_out_beat
);
    import knnsrc_pkg::*;

    localparam int AW = $clog2(PIXELS);

    logic                  r_mask_mem [PIXELS];
    logic [COUNT_BITS-1:0] r_cnt_mem  [PIXELS];

    logic [IDX_W-1:0]      r_pix;
    logic [IDX_W-1:0]      r_nbr;
    logic                  r_p_ok;
    logic                  r_q_ok;
    logic                  r_mask_p;
    logic                  r_mask_q;
    logic [COUNT_BITS-1:0] r_cnt_rd;
    logic                  r_byp_hit;
    logic [COUNT_BITS-1:0] r_byp_data;
    logic                  r_out_valid;
    t_out_beat             r_out_beat;

    logic                  in_p_ok;
    logic                  in_q_ok;
    logic [AW-1:0]         in_p_addr;
    logic [AW-1:0]         in_q_addr;
    logic [AW-1:0]         p_addr;
    logic [AW-1:0]         q_addr;
    logic [AW-1:0]         cnt_rd_addr;
    logic [AW-1:0]         cnt_wr_addr;
    logic                  cnt_wr_en;
    logic [COUNT_BITS-1:0] cnt_eff;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [COUNT_BITS-1:0] n_cnt;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [OUT_CNT_W-1:0]  n_region_count;

    assign in_p_ok   = 32'(i_in_beat.pixel_index) < 32'(PIXELS);
    assign in_q_ok   = 32'(i_in_beat.neighbor_index) < 32'(PIXELS);
    assign in_p_addr = AW'(i_in_beat.pixel_index);
    assign in_q_addr = AW'(i_in_beat.neighbor_index);
    assign p_addr    = AW'(r_pix);
    assign q_addr    = AW'(r_nbr);

    // mask store: written by load beats, both ends of an edge read at accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mask_p <= r_mask_mem[in_p_addr];
            r_mask_q <= r_mask_mem[in_q_addr];
            if (i_in_beat.mode == MODE_LOAD && in_p_ok) begin
                r_mask_mem[in_p_addr] <= i_in_beat.region_bit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix  <= i_in_beat.pixel_index;
            r_nbr  <= i_in_beat.neighbor_index;
            r_p_ok <= in_p_ok;
            r_q_ok <= in_q_ok;
        end
    end

    // count store: one read port, one write port, bypass on any read/write address collision
    always_comb begin
        if (i_cmd.accept) begin
            cnt_rd_addr = in_p_addr;
        end else if (i_cmd.upd_p) begin
            cnt_rd_addr = q_addr;
        end else begin
            cnt_rd_addr = p_addr;
        end
    end

    assign cnt_eff = r_byp_hit ? r_byp_data : r_cnt_rd;
    assign cnt_inc = (cnt_eff == '1) ? cnt_eff : cnt_eff + COUNT_BITS'(1);

    always_comb begin
        cnt_wr_en   = 1'b0;
        cnt_wr_addr = p_addr;
        n_cnt       = cnt_inc;
        if (i_cmd.upd_p) begin
            cnt_wr_en = r_p_ok && r_q_ok && r_mask_q;
        end else if (i_cmd.upd_q) begin
            cnt_wr_en   = r_q_ok && r_p_ok && r_mask_p;
            cnt_wr_addr = q_addr;
        end else if (i_cmd.clr) begin
            cnt_wr_en = r_p_ok;
            n_cnt     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt_rd   <= r_cnt_mem[cnt_rd_addr];
        r_byp_data <= n_cnt;
        if (cnt_wr_en) begin
            r_cnt_mem[cnt_wr_addr] <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_hit <= 1'b0;
        end else begin
            r_byp_hit <= cnt_wr_en && (cnt_wr_addr == cnt_rd_addr);
        end
    end

    // result beat, clipped to the output width
    assign rd_cnt         = r_p_ok ? cnt_eff : '0;
    assign n_region_count = (rd_cnt > COUNT_BITS'({OUT_CNT_W{1'b1}}))
                          ? {OUT_CNT_W{1'b1}} : OUT_CNT_W'(rd_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_beat.pixel_index_out <= r_pix;
            r_out_beat.region_count    <= n_region_count;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_beat     = r_out_beat;

endmodule

>>> design/knn_symmetric_region_count.sv
// a read beat loads its result into the o_out_beat register from S_READ once the output is free
// edge beats hold off the next beat in S_UPD_P and read beats in S_READ; load and unused mode do not
// a read beat holds the input off longer while the previous result beat waits
// the edge rate is set by the single write port of the count memory (one update per cycle)
// reset: synchronous active-low, clears control state only; region mask and count
// memories are not cleared and hold no defined value until written
module knn_symmetric_region_count #(
    parameter int PIXELS     = 65536,
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  knnsrc_pkg::t_in_beat  i_in_beat,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output knnsrc_pkg::t_out_beat o_out_beat
);
    import knnsrc_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    knnsrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_in_beat.mode),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    knnsrc_datapath #(
        .PIXELS     (PIXELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

endmodule

>>> design/knnsrc_checker.sv
`include "assert_macros.svh"

module knnsrc_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input knnsrc_pkg::t_in_beat  i_in_beat,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input knnsrc_pkg::t_out_beat o_out_beat
);
    import knnsrc_pkg::*;

    logic in_acc;
    logic out_stall;

    assign in_acc    = i_in_valid && o_in_ready;
    assign out_stall = o_out_valid && !i_out_ready;

    // stalled result beat is held
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_out_beat))

    // an edge holds off input while S_UPD_P occupies the count port
    `ASSERT_NEXT(a_edge_busy, i_clk, i_rst_n, in_acc && i_in_beat.mode == MODE_EDGE, !o_in_ready)

    // a read holds off input until its result is loaded
    `ASSERT_NEXT(a_read_busy, i_clk, i_rst_n, in_acc && i_in_beat.mode == MODE_READ, !o_in_ready)

    // only reads produce result beats
    `ASSERT_NEXT(a_no_spurious_out, i_clk, i_rst_n,
        in_acc && i_in_beat.mode != MODE_READ && !o_out_valid, !o_out_valid)

endmodule

bind knn_symmetric_region_count knnsrc_checker u_knnsrc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_beat   (i_in_beat),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_beat  (o_out_beat)
);
